/* src/ddcw_pkg.sv */
// shared constants for the dual digest confirm watermark block
package ddcw_pkg;
   localparam int KIND_W = 3;
   localparam int TICK_W = 32;
   localparam int DIGEST_W = 32;
   localparam int RING_DEPTH_DEFAULT = 64;
   localparam logic [TICK_W-1:0] TICK_ALL_ONES = '1;

   localparam logic [KIND_W-1:0] KIND_NOTE_LOCAL = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_PEER = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PRIME = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HEAL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;
endpackage

/* src/ddcw_ram.sv */
// generic single write port ram with registered read
module ddcw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/dual_digest_confirm_watermark_top.sv */
// top level: digest rings, watermark sequencer and result registers
//
// One item at a time: busy rises after an accepted start and falls when the
// result beat is shown on rsp_strobe for one cycle, which the receiver must
// take. An item first reduces its tick to a ring slot, then is dispatched,
// then reads the rings in steps of a read state and an evaluate state: a
// note writes and then advances the watermark one step per confirmed tick,
// a query adds one read, a heal may scan the whole ring, and every item
// ends with a final lookup. Both rings are memories with one read and one
// write port, read once per step; their valid bits are flip-flops, so reset,
// clear and prime take effect at once.
module dual_digest_confirm_watermark_top
   import ddcw_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [TICK_W-1:0]   req_tick,
   input  logic [DIGEST_W-1:0] req_digest,
   output logic                rsp_strobe,
   output logic                rsp_watermark_valid,
   output logic [TICK_W-1:0]   rsp_watermark_tick,
   output logic                rsp_confirmed,
   output logic                rsp_local_found,
   output logic [DIGEST_W-1:0] rsp_local_value,
   output logic                rsp_peer_found,
   output logic [DIGEST_W-1:0] rsp_peer_value,
   output logic                rsp_mismatch,
   output logic [TICK_W-1:0]   rsp_mismatch_tick,
   output logic [DIGEST_W-1:0] rsp_mismatch_local,
   output logic [DIGEST_W-1:0] rsp_mismatch_peer,
   output logic                rsp_healed
);
   localparam int AW = $clog2(RING_DEPTH);
   localparam int RW = AW + 1;
   localparam int EW = TICK_W + DIGEST_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MOD = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_NOTE = 4'd3;
   localparam logic [3:0] S_QRY_RD = 4'd4;
   localparam logic [3:0] S_QRY_EV = 4'd5;
   localparam logic [3:0] S_HEAL_RD = 4'd6;
   localparam logic [3:0] S_HEAL_EV = 4'd7;
   localparam logic [3:0] S_SCAN_RD = 4'd8;
   localparam logic [3:0] S_SCAN_EV = 4'd9;
   localparam logic [3:0] S_HEAL_FIN = 4'd10;
   localparam logic [3:0] S_LOOK_RD = 4'd11;
   localparam logic [3:0] S_LOOK_EV = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [DIGEST_W-1:0] digest_ff, digest_in;
   logic [TICK_W-1:0] sh_ff, sh_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [TICK_W-1:0] wm_ff, wm_in;
   logic wmset_ff, wmset_in;
   logic [AW-1:0] wmslot_ff, wmslot_in;
   logic [RING_DEPTH-1:0] vl_ff, vl_in, vp_ff, vp_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [TICK_W-1:0] best_ff, best_in;
   logic [AW-1:0] bestidx_ff, bestidx_in;
   logic have_ff, have_in, refuse_ff, refuse_in;
   logic [AW-1:0] rslot_ff, raddr;
   logic qconf_ff, qconf_in, qlf_ff, qlf_in, qpf_ff, qpf_in, heal_ff, heal_in;
   logic [DIGEST_W-1:0] qlv_ff, qlv_in, qpv_ff, qpv_in;
   logic strobe_ff, strobe_in;
   logic ov_wv_ff, ov_wv_in, ov_mm_ff, ov_mm_in;
   logic [TICK_W-1:0] ov_wt_ff, ov_wt_in, ov_mt_ff, ov_mt_in;
   logic [DIGEST_W-1:0] ov_ml_ff, ov_ml_in, ov_mp_ff, ov_mp_in;

   logic [EW-1:0] l_rd, p_rd;
   logic l_we, p_we;
   logic [RW-1:0] rem_step;
   logic nxt_valid;
   logic [TICK_W-1:0] nxt_tick, l_tick, p_tick, look_tick;
   logic [DIGEST_W-1:0] l_dig, p_dig;
   logic [AW-1:0] nxt_slot, slot;
   logic lf, pf, eq, is_note;

   assign slot = rem_ff[AW-1:0];
   assign l_tick = l_rd[EW-1:DIGEST_W];
   assign p_tick = p_rd[EW-1:DIGEST_W];
   assign l_dig = l_rd[DIGEST_W-1:0];
   assign p_dig = p_rd[DIGEST_W-1:0];
   assign nxt_valid = !wmset_ff || (wm_ff != TICK_ALL_ONES);
   assign nxt_tick = wmset_ff ? wm_ff + 1'b1 : '0;
   assign nxt_slot = !wmset_ff ? '0 :
      (wmslot_ff == AW'(RING_DEPTH - 1)) ? '0 : wmslot_ff + 1'b1;
   assign is_note = (kind_ff == KIND_NOTE_LOCAL) || (kind_ff == KIND_NOTE_PEER);
   assign look_tick = (state_ff == S_QRY_EV) ? tick_ff : nxt_tick;
   assign lf = vl_ff[rslot_ff] && (l_tick == look_tick);
   assign pf = vp_ff[rslot_ff] && (p_tick == look_tick);
   assign eq = (l_dig == p_dig);
   assign l_we = (state_ff == S_NOTE) && (kind_ff == KIND_NOTE_LOCAL);
   assign p_we = (state_ff == S_NOTE) && (kind_ff == KIND_NOTE_PEER);

   // four remainder bits per cycle
   always_comb begin
      logic [RW-1:0] r;
      r = rem_ff;
      for (int k = 0; k < 4; k++) begin
         r = {r[RW-2:0], sh_ff[TICK_W-1-k]};
         if (r >= RW'(RING_DEPTH)) begin
            r = r - RW'(RING_DEPTH);
         end
      end
      rem_step = r;
   end

   always_comb begin
      unique case (state_ff)
         S_QRY_RD: raddr = slot;
         S_SCAN_RD: raddr = idx_ff;
         default: raddr = nxt_slot;
      endcase
   end

   ddcw_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_local_ram (
      .clock(clock), .wr_en(l_we), .wr_addr(slot), .wr_data({tick_ff, digest_ff}),
      .rd_addr(raddr), .rd_data(l_rd)
   );

   ddcw_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_peer_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(slot), .wr_data({tick_ff, digest_ff}),
      .rd_addr(raddr), .rd_data(p_rd)
   );

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      tick_in = tick_ff;
      digest_in = digest_ff;
      sh_in = sh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      wm_in = wm_ff;
      wmset_in = wmset_ff;
      wmslot_in = wmslot_ff;
      vl_in = vl_ff;
      vp_in = vp_ff;
      idx_in = idx_ff;
      best_in = best_ff;
      bestidx_in = bestidx_ff;
      have_in = have_ff;
      refuse_in = refuse_ff;
      qconf_in = qconf_ff;
      qlf_in = qlf_ff;
      qlv_in = qlv_ff;
      qpf_in = qpf_ff;
      qpv_in = qpv_ff;
      heal_in = heal_ff;
      strobe_in = 1'b0;
      ov_wv_in = ov_wv_ff;
      ov_wt_in = ov_wt_ff;
      ov_mm_in = ov_mm_ff;
      ov_mt_in = ov_mt_ff;
      ov_ml_in = ov_ml_ff;
      ov_mp_in = ov_mp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               tick_in = req_tick;
               digest_in = req_digest;
               sh_in = req_tick;
               rem_in = '0;
               cnt_in = '0;
               qconf_in = 1'b0;
               qlf_in = 1'b0;
               qlv_in = '0;
               qpf_in = 1'b0;
               qpv_in = '0;
               heal_in = 1'b0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            rem_in = rem_step;
            sh_in = {sh_ff[TICK_W-5:0], 4'd0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 3'd7) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (kind_ff)
               KIND_NOTE_LOCAL, KIND_NOTE_PEER: state_in = S_NOTE;
               KIND_PRIME: begin
                  vl_in = '0;
                  vp_in = '0;
                  wm_in = tick_ff;
                  wmset_in = 1'b1;
                  wmslot_in = slot;
                  state_in = S_LOOK_RD;
               end
               KIND_CLEAR: begin
                  vl_in = '0;
                  vp_in = '0;
                  wm_in = '0;
                  wmset_in = 1'b0;
                  wmslot_in = '0;
                  state_in = S_LOOK_RD;
               end
               KIND_QUERY: state_in = S_QRY_RD;
               KIND_HEAL: state_in = (wmset_ff && nxt_valid) ? S_HEAL_RD : S_LOOK_RD;
               default: state_in = S_LOOK_RD;
            endcase
         end
         S_NOTE: begin
            if (kind_ff == KIND_NOTE_LOCAL) begin
               vl_in[slot] = 1'b1;
            end else begin
               vp_in[slot] = 1'b1;
            end
            state_in = S_LOOK_RD;
         end
         S_QRY_RD: state_in = S_QRY_EV;
         S_QRY_EV: begin
            qconf_in = wmset_ff && (tick_ff <= wm_ff);
            qlf_in = lf;
            qlv_in = lf ? l_dig : '0;
            qpf_in = pf;
            qpv_in = pf ? p_dig : '0;
            state_in = S_LOOK_RD;
         end
         S_HEAL_RD: state_in = S_HEAL_EV;
         S_HEAL_EV: begin
            if (lf || pf) begin
               state_in = S_LOOK_RD;
            end else begin
               idx_in = '0;
               have_in = 1'b0;
               refuse_in = 1'b0;
               best_in = '0;
               bestidx_in = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: state_in = S_SCAN_EV;
         S_SCAN_EV: begin
            if (vl_ff[idx_ff] && vp_ff[idx_ff] && (l_tick == p_tick) && (l_tick > wm_ff)) begin
               if (!eq) begin
                  refuse_in = 1'b1;
               end else if (!have_ff || (l_tick > best_ff)) begin
                  have_in = 1'b1;
                  best_in = l_tick;
                  bestidx_in = idx_ff;
               end
            end
            if (idx_ff == AW'(RING_DEPTH - 1)) begin
               state_in = S_HEAL_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_HEAL_FIN: begin
            if (have_ff && !refuse_ff) begin
               wm_in = best_ff;
               wmslot_in = bestidx_ff;
               heal_in = 1'b1;
            end
            state_in = S_LOOK_RD;
         end
         S_LOOK_RD: state_in = S_LOOK_EV;
         S_LOOK_EV: begin
            if (is_note && nxt_valid && lf && pf && eq) begin
               wm_in = nxt_tick;
               wmset_in = 1'b1;
               wmslot_in = nxt_slot;
               state_in = S_LOOK_RD;
            end else begin
               ov_wv_in = wmset_ff;
               ov_wt_in = wmset_ff ? wm_ff : '0;
               ov_mm_in = nxt_valid && lf && pf && !eq;
               ov_mt_in = ov_mm_in ? nxt_tick : '0;
               ov_ml_in = ov_mm_in ? l_dig : '0;
               ov_mp_in = ov_mm_in ? p_dig : '0;
               strobe_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wm_ff <= '0;
         wmset_ff <= 1'b0;
         wmslot_ff <= '0;
         vl_ff <= '0;
         vp_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wm_ff <= wm_in;
         wmset_ff <= wmset_in;
         wmslot_ff <= wmslot_in;
         vl_ff <= vl_in;
         vp_ff <= vp_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      tick_ff <= tick_in;
      digest_ff <= digest_in;
      sh_ff <= sh_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      best_ff <= best_in;
      bestidx_ff <= bestidx_in;
      have_ff <= have_in;
      refuse_ff <= refuse_in;
      rslot_ff <= raddr;
      qconf_ff <= qconf_in;
      qlf_ff <= qlf_in;
      qlv_ff <= qlv_in;
      qpf_ff <= qpf_in;
      qpv_ff <= qpv_in;
      heal_ff <= heal_in;
      ov_wv_ff <= ov_wv_in;
      ov_wt_ff <= ov_wt_in;
      ov_mm_ff <= ov_mm_in;
      ov_mt_ff <= ov_mt_in;
      ov_ml_ff <= ov_ml_in;
      ov_mp_ff <= ov_mp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_watermark_valid = ov_wv_ff;
   assign rsp_watermark_tick = ov_wt_ff;
   assign rsp_confirmed = qconf_ff;
   assign rsp_local_found = qlf_ff;
   assign rsp_local_value = qlv_ff;
   assign rsp_peer_found = qpf_ff;
   assign rsp_peer_value = qpv_ff;
   assign rsp_mismatch = ov_mm_ff;
   assign rsp_mismatch_tick = ov_mt_ff;
   assign rsp_mismatch_local = ov_ml_ff;
   assign rsp_mismatch_peer = ov_mp_ff;
   assign rsp_healed = heal_ff;

`ifndef SYNTHESIS
   a_strobe_after_look: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_LOOK_EV))
      else $error("result beat without final lookup");
   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");
   a_wm_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_watermark_valid) |->
         (rsp_watermark_tick == '0) && (rsp_mismatch_tick == '0))
      else $error("watermark tick set without valid watermark");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DISPATCH) |-> (rem_ff < RW'(RING_DEPTH)))
      else $error("slot out of range");
`endif
endmodule
